// File: sv/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the periodic task dispatcher
// Sizes of the task table, operation codes, result codes and the layout
// of one task table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Table geometry.
  localparam int TASK_SLOTS  = 8;
  localparam int PERIOD_BITS = 16;
  localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TIME_W      = 32;

  // Operation codes carried in the func field.
  typedef enum logic [2:0] {
    FN_ADD      = 3'd0,
    FN_REMOVE   = 3'd1,
    FN_ACTIVATE = 3'd2,
    FN_SUSPEND  = 3'd3,
    FN_TERM     = 3'd4,
    FN_TICK     = 3'd5,
    FN_SETPER   = 3'd6,
    FN_NOP      = 3'd7
  } func_t;

  // Task modes.
  typedef enum logic [1:0] {
    MODE_ACTIVE    = 2'd0,
    MODE_SUSPENDED = 2'd1,
    MODE_TERM      = 2'd2
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_DUE    = 2'd1,
    KIND_REAPED = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One entry of the task table memory.
  typedef struct packed {
    mode_t                  mode;
    logic [PERIOD_BITS-1:0] period;
    logic [TIME_W-1:0]      due;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: sv/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: table of periodic tasks with a tick walk
// Keeps mode, period and due time of each task in a RAM, with used bits
// in flip-flops, and answers task operations and millisecond ticks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Word
//   in_*     input      in_valid/in_stall  func, slot, period, now_ms
//   out_*    output     out_valid/out_stall kind, task_slot, status, last
//
// A task operation reads the addressed entry in the accepting cycle; in
// S_OP it updates the entry and loads the acknowledge into the output
// register. A tick walks the slots in order, reading one entry per cycle
// through the single read port of the task RAM while the output does not
// stall, then emits the done word.
// Reset clears the used bits, the stored time and the control state; the
// RAM contents need no clearing. A stalled output holds the walk at the
// slot whose word waits; no input is taken until the current one is done.
`default_nettype none

module periodic_task_dispatcher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_func,
  input  wire logic [2:0] in_slot,
  input  wire logic [15:0] in_period,
  input  wire logic [31:0] in_now_ms,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_task_slot,
  output logic [1:0]      out_status,
  output logic            out_last
);

  import ptd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TASK_SLOTS-1:0]  used_r, used_nxt;
  logic [TIME_W-1:0]      time_r, time_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  func_t                  func_r;
  logic [2:0]             slot_r;
  logic [PERIOD_BITS-1:0] period_r;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [2:0]             tslot_r, tslot_nxt;
  status_t                status_r, status_nxt;
  logic                   last_r, last_nxt;

  logic                   in_accept;
  logic                   out_free;
  logic                   emit;

  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  entry_t                 wr_data;
  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  entry_t                 rd_data;
  logic [ENTRY_W-1:0]     rd_bits;

  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_W-1:0]      op_idx;
  logic                   op_hit;
  logic [TIME_W-1:0]      due_adv;
  logic [TIME_W-1:0]      due_resync;
  logic [TIME_W-1:0]      period_ext;
  logic [TIME_W-1:0]      due_lag;
  logic [TIME_W-1:0]      due_ahead;
  logic                   tick_last_slot;

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Task table memory.
  ptd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_task_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );
  assign rd_data = entry_t'(rd_bits);

  // Lowest free slot for add.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (!used_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Addressed slot of an operation and whether it holds a task.
  assign op_idx = SLOT_W'(slot_r);
  assign op_hit = (7'(slot_r) < 7'(TASK_SLOTS)) && used_r[op_idx];

  // Due time update of a tick: advance by one period, resync when behind.
  assign period_ext = TIME_W'(rd_data.period);
  assign due_adv    = rd_data.due + period_ext;
  assign due_resync = time_r + period_ext;
  assign due_lag    = time_r - rd_data.due;
  assign due_ahead  = due_adv - time_r;

  assign tick_last_slot = (idx_r == SLOT_W'(TASK_SLOTS - 1));

  // Control and datapath.
  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    time_nxt   = time_r;
    idx_nxt    = idx_r;
    emit       = 1'b0;
    kind_nxt   = KIND_ACK;
    tslot_nxt  = slot_r;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = op_idx;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          rd_en = 1'b1;
          if (func_t'(in_func) == FN_TICK) begin
            time_nxt  = in_now_ms;
            idx_nxt   = '0;
            rd_addr   = '0;
            state_nxt = S_TICK;
          end else begin
            rd_addr   = SLOT_W'(in_slot);
            state_nxt = S_OP;
          end
        end
      end

      S_OP: begin
        emit = 1'b1;
        priority if (func_r == FN_ADD) begin
          if (free_found) begin
            tslot_nxt      = 3'(free_idx);
            wr_addr        = free_idx;
            wr_data.mode   = MODE_ACTIVE;
            wr_data.period = period_r;
            wr_data.due    = time_r;
            wr_en          = out_free;
            if (out_free) begin
              used_nxt[free_idx] = 1'b1;
            end
          end else begin
            tslot_nxt  = '0;
            status_nxt = ST_FULL;
          end
        end else if (func_r == FN_NOP || func_r == FN_TICK) begin
          status_nxt = ST_OK;
        end else if (!op_hit) begin
          status_nxt = ST_EMPTY;
        end else begin
          unique case (func_r)
            FN_REMOVE: begin
              if (out_free) begin
                used_nxt[op_idx] = 1'b0;
              end
            end
            FN_ACTIVATE: begin
              wr_data.mode = MODE_ACTIVE;
              wr_data.due  = due_resync;
              wr_en        = out_free;
            end
            FN_SUSPEND: begin
              if (rd_data.mode == MODE_ACTIVE) begin
                wr_data.mode = MODE_SUSPENDED;
              end
              wr_en = out_free;
            end
            FN_TERM: begin
              wr_data.mode = MODE_TERM;
              wr_en        = out_free;
            end
            default: begin
              wr_data.period = period_r;
              wr_en          = out_free;
            end
          endcase
        end
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      S_TICK: begin
        // Entry idx_r is on the read port this cycle.
        tslot_nxt = 3'(idx_r);
        last_nxt  = 1'b0;
        wr_addr   = idx_r;
        if (used_r[idx_r]) begin
          if (rd_data.mode == MODE_TERM) begin
            emit     = 1'b1;
            kind_nxt = KIND_REAPED;
            if (out_free) begin
              used_nxt[idx_r] = 1'b0;
            end
          end else if (rd_data.mode == MODE_ACTIVE && !due_lag[TIME_W-1]) begin
            emit     = 1'b1;
            kind_nxt = KIND_DUE;
            wr_en    = out_free;
            if (due_ahead[TIME_W-1]) begin
              wr_data.due = due_resync;
            end else begin
              wr_data.due = due_adv;
            end
          end
        end
        if (!emit || out_free) begin
          if (tick_last_slot) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + SLOT_W'(1);
          end
        end
      end

      S_DONE: begin
        emit      = 1'b1;
        kind_nxt  = KIND_DONE;
        tslot_nxt = '0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_accept) begin
      func_r   <= func_t'(in_func);
      slot_r   <= in_slot;
      period_r <= PERIOD_BITS'(in_period);
    end
    if (emit && out_free) begin
      kind_r   <= kind_nxt;
      tslot_r  <= tslot_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_task_slot = tslot_r;
  assign out_status    = status_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// File: sv/ptd_ram.sv
// ----------------------------------------------------------------------------
// ptd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker: port-level checks of the periodic task dispatcher
// Watches both channels and checks result framing and input pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [2:0] out_task_slot,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);

  import ptd_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_task_slot) && $stable(out_status) && $stable(out_last))
    else $error("stalled result word changed");

  // An accepted word blocks the input until its results are under way.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  // The done word closes a tick, carries slot zero and status ok.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last && out_task_slot == 3'd0 &&
      out_status == ST_OK)
    else $error("malformed tick done word");

  // Due and reaped words are never the last word, and always report ok.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DUE || out_kind == KIND_REAPED) |->
      !out_last && out_status == ST_OK)
    else $error("malformed due or reaped word");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_task_slot (out_task_slot),
  .out_status    (out_status),
  .out_last      (out_last)
);

`default_nettype wire
